// ===== rtl/core/tpw_pkg.sv =====
`timescale 1ns / 1ps

package tpw_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] FAULT_ADDR    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] LOW22_MASK    = 32'h003F_FFFF;
    localparam logic [WORD_W-1:0] LOW12_MASK    = 32'h0000_0FFF;
    localparam int                PRESENT_BIT   = 0;
    localparam int                BIG_PAGE_BIT  = 7;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ABSENT  = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_WRITE     = 1'b0,
        FUNC_TRANSLATE = 1'b1
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE    = 2'd2;

    typedef enum logic [2:0] {
        WALK_CLEAR,
        WALK_IDLE,
        WALK_DIR,
        WALK_TBL,
        WALK_HOLD
    } walk_state_t;

endpackage

// ===== rtl/core/tpw_ram.sv =====
`timescale 1ns / 1ps

module tpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/two_level_page_walk_core.sv =====
`timescale 1ns / 1ps

// Two-level 32-bit x86 page walker over a local word store of STORE_WORDS
// words mapped at store_base. After reset the store is swept to zero, one
// word per cycle; no item is taken during the sweep, though configuration
// writes are. Afterwards one item is handled at a time and each result lands
// in an output register. A table write or a pass-through translation ends in
// the idle state that takes it, a 4 MB mapping after the directory read and a
// full walk after the directory and table reads, each read going through the
// single registered read port of the store RAM. The next item is taken in the
// cycle after the result is loaded, even while that result waits for out_ready.
module two_level_page_walk_core #(
    parameter int STORE_WORDS = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpw_pkg::WORD_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [31:0]                    phys_addr,
    input  logic [31:0]                    write_data,
    input  logic [31:0]                    virt_addr,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    phys_result,
    output logic [1:0]                     status
);

    import tpw_pkg::*;

    localparam int                AW          = $clog2(STORE_WORDS);
    localparam logic [31:0]       STORE_BYTES = 32'(4 * STORE_WORDS);
    localparam logic [AW-1:0]     LAST_WORD   = AW'(STORE_WORDS - 1);

    walk_state_t   state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          paging_enable_reg;
    logic [31:0]   dir_base_reg;
    logic [31:0]   store_base_reg;

    logic [31:0]   va_reg, va_next;
    logic [31:0]   pend_result_reg, pend_result_next;
    status_t       pend_status_reg, pend_status_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_result_reg, out_result_next;
    status_t       out_status_reg, out_status_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          out_free;
    logic          take;
    logic          fin;
    logic [31:0]   fin_result;
    status_t       fin_status;

    logic [31:0]   wr_off;
    logic [31:0]   dir_addr;
    logic [31:0]   dir_off;
    logic [31:0]   tbl_addr;
    logic [31:0]   tbl_off;

    tpw_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == WALK_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign wr_off   = phys_addr - store_base_reg;
    assign dir_addr = (dir_base_reg & ~LOW12_MASK) + {20'd0, virt_addr[31:22], 2'b00};
    assign dir_off  = dir_addr - store_base_reg;
    assign tbl_addr = (ram_rdata & ~LOW12_MASK) + {20'd0, va_reg[21:12], 2'b00};
    assign tbl_off  = tbl_addr - store_base_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        va_next          = va_reg;
        pend_result_next = pend_result_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_result_next  = out_result_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = wr_off[AW+1:2];
        ram_wdata        = write_data;
        ram_raddr        = dir_off[AW+1:2];
        fin              = 1'b0;
        fin_result       = FAULT_ADDR;
        fin_status       = STATUS_OUTSIDE;

        case (state_reg)
            WALK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = WALK_IDLE;
                end
            end
            WALK_IDLE:
            begin
                va_next = virt_addr;
                if (take)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        fin        = 1'b1;
                        fin_result = '0;
                        if (wr_off < STORE_BYTES)
                        begin
                            ram_we     = 1'b1;
                            fin_status = STATUS_OK;
                        end
                    end
                    else if (!paging_enable_reg)
                    begin
                        fin        = 1'b1;
                        fin_result = virt_addr;
                        fin_status = STATUS_OK;
                    end
                    else if (dir_off < STORE_BYTES)
                    begin
                        state_next = WALK_DIR;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            WALK_DIR:
            begin
                ram_raddr = tbl_off[AW+1:2];
                if (!ram_rdata[PRESENT_BIT])
                begin
                    fin        = 1'b1;
                    fin_status = STATUS_ABSENT;
                end
                else if (ram_rdata[BIG_PAGE_BIT])
                begin
                    fin        = 1'b1;
                    fin_result = (ram_rdata & ~LOW22_MASK) + (va_reg & LOW22_MASK);
                    fin_status = STATUS_OK;
                end
                else if (tbl_off < STORE_BYTES)
                begin
                    state_next = WALK_TBL;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            WALK_TBL:
            begin
                fin = 1'b1;
                if (!ram_rdata[PRESENT_BIT])
                begin
                    fin_status = STATUS_ABSENT;
                end
                else
                begin
                    fin_result = (ram_rdata & ~LOW12_MASK) + (va_reg & LOW12_MASK);
                    fin_status = STATUS_OK;
                end
            end
            WALK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = pend_result_reg;
                    out_status_next = pend_status_reg;
                    state_next      = WALK_IDLE;
                end
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase

        // load the result now, or park it until the output register frees up
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_result_next = fin_result;
                out_status_next = fin_status;
                state_next      = WALK_IDLE;
            end
            else
            begin
                pend_result_next = fin_result;
                pend_status_next = fin_status;
                state_next       = WALK_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= WALK_CLEAR;
            clr_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            paging_enable_reg <= 1'b0;
            dir_base_reg      <= '0;
            store_base_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_PAGING_ENABLE: paging_enable_reg <= cfg_data[0];
                    CFG_DIR_BASE:      dir_base_reg      <= cfg_data;
                    CFG_STORE_BASE:    store_base_reg    <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg          <= va_next;
        pend_result_reg <= pend_result_next;
        pend_status_reg <= pend_status_next;
        out_result_reg  <= out_result_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign phys_result = out_result_reg;
    assign status      = out_status_reg;

endmodule
